// File: rtl/srsg_pkg.sv
// Shared types and constants of the stepper ramp step generator.
// Used by every module of the block; depends on nothing.
package srsg_pkg;

    localparam int SPEED_MAX_INT = 10000;
    localparam int PHASE_WRAP_INT = 10000;
    localparam int DECEL_DIV_INT = 20000;

    localparam logic [13:0] SPEED_MAX = 14'(SPEED_MAX_INT);
    localparam logic [14:0] PHASE_WRAP = 15'(PHASE_WRAP_INT);
    localparam logic [27:0] DECEL_DIV = 28'(DECEL_DIV_INT);
    localparam logic [30:0] LINE_MAX = 31'(SPEED_MAX_INT * SPEED_MAX_INT / DECEL_DIV_INT);

    localparam logic [1:0] DIR_STOP    = 2'd0;
    localparam logic [1:0] DIR_FWD     = 2'd1;
    localparam logic [1:0] DIR_REV     = 2'd2;
    localparam logic [1:0] DIR_REV_ALT = 2'd3;

    localparam logic [1:0] REG_TARGET_SPEED = 2'd0;
    localparam logic [1:0] REG_ACCEL_ENABLE = 2'd1;
    localparam logic [1:0] REG_RUN_FOREVER  = 2'd2;
    localparam logic [1:0] REG_CLOCK_MODE   = 2'd3;

    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_LOAD = 1'b1
    } kind_t;

    typedef struct packed {
        logic [13:0] target_speed;
        logic        accel_enable;
        logic        run_forever;
        logic        clock_mode;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  direction;
        logic [30:0] step_count;
        logic [13:0] start_speed;
    } item_t;

    typedef struct packed {
        logic [1:0]         move_dir;
        logic [30:0]        remaining;
        logic signed [31:0] position;
        logic [13:0]        ramp_speed;
        logic [14:0]        phase;
        logic               accelerating;
        logic               decelerating;
        logic               clk_held;
        logic               dir_level;
    } state_t;

endpackage

// File: rtl/stepper_ramp_step_generator_top.sv
// Stepper ramp step generator: one result transfer for every input transfer.
// An input transfer passes an input register, then the step logic and the result
// register. Throughput is one item per cycle while the output is not stalled by
// m_tready; the channel state updates as an item leaves the input register. A
// synchronous active-low reset clears the state, the configuration and both valid flags.
// Depends on srsg_pkg and srsg_step_core.
module stepper_ramp_step_generator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // direction[1:0], step_count[32:2], start_speed[46:33]
    input  logic        s_tuser,  // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,  // step_pulse, dir_pin, clock_level, position[34:3],
                                  // steps_left[65:35], busy_res, current_speed[80:67]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_wdata
);

    srsg_pkg::cfg_t   cfg_reg;
    srsg_pkg::state_t state_reg;
    srsg_pkg::state_t state_next;
    srsg_pkg::item_t  item_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic [87:0]      out_data_reg;
    logic [87:0]      out_data_next;
    logic             step;
    logic             advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                srsg_pkg::REG_TARGET_SPEED: cfg_reg.target_speed <= cfg_wdata;
                srsg_pkg::REG_ACCEL_ENABLE: cfg_reg.accel_enable <= cfg_wdata[0];
                srsg_pkg::REG_RUN_FOREVER:  cfg_reg.run_forever  <= cfg_wdata[0];
                srsg_pkg::REG_CLOCK_MODE:   cfg_reg.clock_mode   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.kind        <= srsg_pkg::kind_t'(s_tuser);
            item_reg.direction   <= s_tdata[1:0];
            item_reg.step_count  <= s_tdata[32:2];
            item_reg.start_speed <= s_tdata[46:33];
        end
    end

    srsg_step_core u_core (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .step       (step)
    );

    assign out_data_next = {7'd0,
                            state_next.ramp_speed,
                            state_next.move_dir != srsg_pkg::DIR_STOP,
                            state_next.remaining,
                            state_next.position,
                            state_next.clk_held,
                            state_next.dir_level,
                            step};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    a_phase_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase < srsg_pkg::PHASE_WRAP)
        else $error("phase accumulator left its range");

    a_speed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.ramp_speed <= srsg_pkg::SPEED_MAX)
        else $error("ramped speed above the maximum");

    a_ramp_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(state_reg.accelerating && state_reg.decelerating))
        else $error("accelerating and decelerating at once");

    a_step_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && step |=> out_data_reg[66] && state_reg.move_dir != srsg_pkg::DIR_STOP)
        else $error("step issued without an active move");

endmodule

// File: rtl/srsg_decel_check.sv
// Deceleration line test: steps left below speed squared over 20000.
// Depends on srsg_pkg for the constants.
module srsg_decel_check (
    input  logic [13:0] speed,
    input  logic [30:0] steps_left,
    output logic        start_decel
);

    logic [27:0] speed_sq;
    logic [27:0] line_lhs;
    logic        below_max;

    assign speed_sq  = 28'(speed) * 28'(speed);
    assign below_max = steps_left < srsg_pkg::LINE_MAX;
    assign line_lhs  = (28'(steps_left[12:0]) + 28'd1) * srsg_pkg::DECEL_DIV;

    assign start_decel = below_max && (line_lhs <= speed_sq);

endmodule

// File: rtl/srsg_step_core.sv
// Next-state logic for one tick or load item of the stepper channel.
// Depends on srsg_pkg and srsg_decel_check.
module srsg_step_core (
    input  srsg_pkg::cfg_t   cfg,
    input  srsg_pkg::state_t state,
    input  srsg_pkg::item_t  item,
    output srsg_pkg::state_t state_next,
    output logic             step
);

    logic [13:0] tgt;
    logic [13:0] ramped;
    logic        acc_ramped;
    logic [13:0] line_speed;
    logic [30:0] remaining_dec;
    logic        start_decel;

    assign tgt = (cfg.target_speed > srsg_pkg::SPEED_MAX) ? srsg_pkg::SPEED_MAX
                                                          : cfg.target_speed;
    assign remaining_dec = state.remaining - 31'd1;

    always_comb begin
        ramped     = state.ramp_speed;
        acc_ramped = state.accelerating;
        if (state.accelerating) begin
            if (ramped < tgt) begin
                ramped = ramped + 14'd1;
            end else begin
                acc_ramped = 1'b0;
            end
        end
        if (!cfg.run_forever && state.decelerating && ramped > 14'd1) begin
            ramped = ramped - 14'd1;
        end
        line_speed = cfg.accel_enable ? ramped : state.ramp_speed;
    end

    srsg_decel_check u_decel (
        .speed       (line_speed),
        .steps_left  (remaining_dec),
        .start_decel (start_decel)
    );

    always_comb begin
        logic [14:0] sum;
        logic        halted;
        state_next = state;
        step       = 1'b0;
        sum        = '0;
        halted     = 1'b0;
        if (item.kind == srsg_pkg::KIND_LOAD) begin
            state_next.move_dir     = item.direction;
            state_next.remaining    = item.step_count;
            state_next.ramp_speed   = (item.start_speed > srsg_pkg::SPEED_MAX)
                                      ? srsg_pkg::SPEED_MAX : item.start_speed;
            state_next.accelerating = 1'b1;
            state_next.decelerating = 1'b0;
        end else if (state.move_dir != srsg_pkg::DIR_STOP) begin
            if (cfg.accel_enable) begin
                state_next.ramp_speed   = ramped;
                state_next.accelerating = acc_ramped;
                sum = state.phase + 15'(ramped);
            end else begin
                sum = state.phase + 15'(tgt);
            end
            if (sum >= srsg_pkg::PHASE_WRAP) begin
                state_next.phase = sum - srsg_pkg::PHASE_WRAP;
                if (!cfg.run_forever) begin
                    if (state.remaining != 31'd0) begin
                        state_next.remaining = remaining_dec;
                        if (!state.decelerating && start_decel) begin
                            state_next.decelerating = 1'b1;
                            state_next.accelerating = 1'b0;
                        end
                    end else begin
                        state_next.move_dir = srsg_pkg::DIR_STOP;
                        halted = 1'b1;
                    end
                end
                if (!halted) begin
                    if (state.move_dir == srsg_pkg::DIR_FWD) begin
                        state_next.dir_level = 1'b0;
                        state_next.position  = state.position + 32'sd1;
                    end else begin
                        state_next.dir_level = 1'b1;
                        state_next.position  = state.position - 32'sd1;
                    end
                    if (cfg.clock_mode) begin
                        state_next.clk_held = !state.clk_held;
                    end
                    step = 1'b1;
                end
            end else begin
                state_next.phase = sum;
            end
        end
    end

endmodule

// File: tb/sv/stepper_ramp_step_generator_top_tb.sv
// Testbench for stepper_ramp_step_generator_top: drives tick and load transfers and
// compares each result transfer with a cycle-free model of the ramp and step logic.
// Depends on srsg_pkg and the RTL of the block; needs no files or arguments.
module stepper_ramp_step_generator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [13:0] speed;
        logic        busy;
        logic [30:0] left;
        logic [31:0] pos;
        logic        clk_lvl;
        logic        dir_pin;
        logic        step;
    } motion_res_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [13:0] cfg_wdata;

    stepper_ramp_step_generator_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Model copy of the configuration and the channel state.
    logic [13:0] cfg_target;
    logic        cfg_accel;
    logic        cfg_forever;
    logic        cfg_clkmode;
    logic [1:0]  mv_dir;
    logic [30:0] steps_rem;
    logic [31:0] pos_cnt;
    logic [13:0] ramp_spd;
    int unsigned phase_acc;
    logic        accel_on;
    logic        decel_on;
    logic        clk_lvl;
    logic        dir_lvl;

    motion_res_t motion_exp_q[$];
    motion_res_t got_res;
    motion_res_t exp_res;
    int          mismatch_cnt;
    int          cycle_cnt;
    int          send_idle_pct;
    int          recv_idle_pct;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_cnt < 100)
            $display("mismatch %s: got %0h, expected %0h at cycle %0d",
                     what, got, want, cycle_cnt);
        mismatch_cnt++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_res = m_tdata[80:0];
            if (motion_exp_q.size() == 0) begin
                report_mismatch("unexpected result", got_res.pos, '0);
            end else begin
                exp_res = motion_exp_q.pop_front();
                if (got_res.step !== exp_res.step)
                    report_mismatch("step_pulse", 32'(got_res.step), 32'(exp_res.step));
                if (got_res.dir_pin !== exp_res.dir_pin)
                    report_mismatch("dir_pin", 32'(got_res.dir_pin),
                                    32'(exp_res.dir_pin));
                if (got_res.clk_lvl !== exp_res.clk_lvl)
                    report_mismatch("clock_level", 32'(got_res.clk_lvl),
                                    32'(exp_res.clk_lvl));
                if (got_res.pos !== exp_res.pos)
                    report_mismatch("position", got_res.pos, exp_res.pos);
                if (got_res.left !== exp_res.left)
                    report_mismatch("steps_left", 32'(got_res.left), 32'(exp_res.left));
                if (got_res.busy !== exp_res.busy)
                    report_mismatch("busy_res", 32'(got_res.busy), 32'(exp_res.busy));
                if (got_res.speed !== exp_res.speed)
                    report_mismatch("current_speed", 32'(got_res.speed),
                                    32'(exp_res.speed));
            end
        end
    end

    task automatic predict_motion(input srsg_pkg::item_t it);
        motion_res_t res;
        logic [13:0] tgt;
        logic        stepped;
        logic        do_step;
        int          sp;
        int          line;
        tgt = (cfg_target > srsg_pkg::SPEED_MAX) ? srsg_pkg::SPEED_MAX : cfg_target;
        stepped = 1'b0;
        if (it.kind == srsg_pkg::KIND_LOAD) begin
            mv_dir = it.direction;
            steps_rem = it.step_count;
            ramp_spd = (it.start_speed > srsg_pkg::SPEED_MAX) ? srsg_pkg::SPEED_MAX
                                                              : it.start_speed;
            accel_on = 1'b1;
            decel_on = 1'b0;
        end else if (mv_dir != srsg_pkg::DIR_STOP) begin
            if (cfg_accel) begin
                if (accel_on) begin
                    if (ramp_spd < tgt)
                        ramp_spd = ramp_spd + 14'd1;
                    else
                        accel_on = 1'b0;
                end
                if (!cfg_forever && decel_on && ramp_spd > 14'd1)
                    ramp_spd = ramp_spd - 14'd1;
                phase_acc = phase_acc + 32'(ramp_spd);
            end else begin
                phase_acc = phase_acc + 32'(tgt);
            end
            if (phase_acc >= srsg_pkg::PHASE_WRAP_INT) begin
                phase_acc = phase_acc - srsg_pkg::PHASE_WRAP_INT;
                do_step = 1'b1;
                if (!cfg_forever) begin
                    if (steps_rem > 0) begin
                        steps_rem = steps_rem - 31'd1;
                        if (!decel_on) begin
                            sp = int'(ramp_spd);
                            line = sp * sp / srsg_pkg::DECEL_DIV_INT;
                            if (int'(steps_rem) < line) begin
                                decel_on = 1'b1;
                                accel_on = 1'b0;
                            end
                        end
                    end else begin
                        mv_dir = srsg_pkg::DIR_STOP;
                        do_step = 1'b0;
                    end
                end
                if (do_step) begin
                    if (mv_dir == srsg_pkg::DIR_FWD) begin
                        dir_lvl = 1'b0;
                        pos_cnt = pos_cnt + 32'd1;
                    end else begin
                        dir_lvl = 1'b1;
                        pos_cnt = pos_cnt - 32'd1;
                    end
                    if (cfg_clkmode)
                        clk_lvl = ~clk_lvl;
                    stepped = 1'b1;
                end
            end
        end
        res.step = stepped;
        res.dir_pin = dir_lvl;
        res.clk_lvl = clk_lvl;
        res.pos = pos_cnt;
        res.left = steps_rem;
        res.busy = (mv_dir != srsg_pkg::DIR_STOP);
        res.speed = ramp_spd;
        motion_exp_q.push_back(res);
    endtask

    function automatic srsg_pkg::item_t make_item(input srsg_pkg::kind_t k,
                                                  input logic [1:0] dir,
                                                  input logic [30:0] cnt,
                                                  input logic [13:0] spd);
        srsg_pkg::item_t it;
        it.kind = k;
        it.direction = dir;
        it.step_count = cnt;
        it.start_speed = spd;
        return it;
    endfunction

    // Called and left at a falling edge; tvalid stays high when the next item follows.
    task automatic send_item(input srsg_pkg::item_t it);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, it.start_speed, it.step_count, it.direction};
        s_tuser <= it.kind;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_motion(it);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (motion_exp_q.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [13:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            srsg_pkg::REG_TARGET_SPEED: cfg_target = val;
            srsg_pkg::REG_ACCEL_ENABLE: cfg_accel = val[0];
            srsg_pkg::REG_RUN_FOREVER:  cfg_forever = val[0];
            srsg_pkg::REG_CLOCK_MODE:   cfg_clkmode = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic test_stopped_ticks();
        repeat (2) send_item(make_item(srsg_pkg::KIND_TICK, srsg_pkg::DIR_STOP, '0, '0));
    endtask

    task automatic test_plain_speed_moves();
        wait_drained();
        cfg_write(srsg_pkg::REG_TARGET_SPEED, srsg_pkg::SPEED_MAX);
        cfg_write(srsg_pkg::REG_ACCEL_ENABLE, 14'd0);
        cfg_write(srsg_pkg::REG_RUN_FOREVER, 14'd0);
        cfg_write(srsg_pkg::REG_CLOCK_MODE, 14'd0);
        send_item(make_item(srsg_pkg::KIND_LOAD, srsg_pkg::DIR_FWD, 31'd2, 14'd0));
        repeat (4) send_item(make_item(srsg_pkg::KIND_TICK, srsg_pkg::DIR_STOP, '0, '0));
        // Direction code three runs in reverse.
        send_item(make_item(srsg_pkg::KIND_LOAD, srsg_pkg::DIR_REV_ALT, 31'd1, 14'h3FFF));
        repeat (2) send_item(make_item(srsg_pkg::KIND_TICK, srsg_pkg::DIR_STOP, '0, '0));
        send_item(make_item(srsg_pkg::KIND_LOAD, srsg_pkg::DIR_STOP, 31'h7FFF_FFFF,
                            srsg_pkg::SPEED_MAX));
        send_item(make_item(srsg_pkg::KIND_TICK, srsg_pkg::DIR_STOP, '0, '0));
    endtask

    task automatic test_saturated_ramp();
        wait_drained();
        cfg_write(srsg_pkg::REG_TARGET_SPEED, 14'h3FFF);
        cfg_write(srsg_pkg::REG_ACCEL_ENABLE, 14'd1);
        cfg_write(srsg_pkg::REG_CLOCK_MODE, 14'd1);
        send_item(make_item(srsg_pkg::KIND_LOAD, srsg_pkg::DIR_REV, 31'h7FFF_FFFF,
                            14'h3FFF));
        repeat (3) send_item(make_item(srsg_pkg::KIND_TICK, srsg_pkg::DIR_STOP, '0, '0));
    endtask

    task automatic test_start_above_target();
        wait_drained();
        cfg_write(srsg_pkg::REG_TARGET_SPEED, 14'd0);
        cfg_write(srsg_pkg::REG_RUN_FOREVER, 14'd1);
        send_item(make_item(srsg_pkg::KIND_LOAD, srsg_pkg::DIR_FWD, 31'd0, 14'd5000));
        repeat (3) send_item(make_item(srsg_pkg::KIND_TICK, srsg_pkg::DIR_STOP, '0, '0));
    endtask

    task automatic test_random_moves(input int n_items, input int send_pct, input int recv_pct);
        int          sent;
        int          pick;
        logic [13:0] tspd;
        logic [1:0]  dir;
        logic [30:0] cnt;
        logic [13:0] spd;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(2) == 0) begin
                wait_drained();
                pick = $urandom_range(4);
                case (pick)
                    0: tspd = 14'd0;
                    1: tspd = srsg_pkg::SPEED_MAX;
                    2: tspd = 14'h3FFF;
                    3: tspd = 14'($urandom);
                    default: tspd = 14'($urandom_range(srsg_pkg::SPEED_MAX_INT, 4000));
                endcase
                cfg_write(srsg_pkg::REG_TARGET_SPEED, tspd);
                cfg_write(srsg_pkg::REG_ACCEL_ENABLE, 14'($urandom_range(3) != 0));
                cfg_write(srsg_pkg::REG_RUN_FOREVER, 14'($urandom_range(4) == 0));
                cfg_write(srsg_pkg::REG_CLOCK_MODE, 14'($urandom_range(1)));
            end
            pick = $urandom_range(9);
            if (pick < 4)
                dir = srsg_pkg::DIR_FWD;
            else if (pick < 8)
                dir = srsg_pkg::DIR_REV;
            else if (pick == 8)
                dir = srsg_pkg::DIR_REV_ALT;
            else
                dir = srsg_pkg::DIR_STOP;
            cnt = ($urandom_range(6) == 0) ? 31'($urandom) : 31'($urandom_range(80));
            spd = ($urandom_range(3) == 0) ? 14'($urandom)
                                           : 14'($urandom_range(srsg_pkg::SPEED_MAX_INT));
            send_item(make_item(srsg_pkg::KIND_LOAD, dir, cnt, spd));
            sent++;
            repeat ($urandom_range(60, 8)) begin
                if (sent >= n_items)
                    break;
                if ($urandom_range(19) == 0)
                    send_item(make_item(srsg_pkg::kind_t'($urandom_range(1)), 2'($urandom),
                                        31'($urandom), 14'($urandom)));
                else
                    send_item(make_item(srsg_pkg::KIND_TICK, srsg_pkg::DIR_STOP, '0, '0));
                sent++;
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        cycle_cnt = 0;
        mismatch_cnt = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cfg_target = '0;
        cfg_accel = 1'b0;
        cfg_forever = 1'b0;
        cfg_clkmode = 1'b0;
        mv_dir = srsg_pkg::DIR_STOP;
        steps_rem = '0;
        pos_cnt = '0;
        ramp_spd = '0;
        phase_acc = 0;
        accel_on = 1'b0;
        decel_on = 1'b0;
        clk_lvl = 1'b0;
        dir_lvl = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_stopped_ticks();
        test_plain_speed_moves();
        test_saturated_ramp();
        test_start_above_target();
        test_random_moves(217, 24, 68);
        test_random_moves(217, 68, 24);
        test_random_moves(217, 0, 0);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (motion_exp_q.size() != 0)
            report_mismatch("results missing", 32'(motion_exp_q.size()), '0);
        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/srsg_pkg.sv
rtl/srsg_decel_check.sv
rtl/srsg_step_core.sv
rtl/stepper_ramp_step_generator_top.sv
tb/sv/stepper_ramp_step_generator_top_tb.sv
